FILE: rtl/signed_varint_encoder_assert.svh
`ifndef SIGNED_VARINT_ENCODER_ASSERT_SVH
`define SIGNED_VARINT_ENCODER_ASSERT_SVH

// same-cycle implication, checked on clk outside reset
`define SVE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on clk outside reset
`define SVE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/sve_pkg.sv
package sve_pkg;

    localparam int unsigned VALUE_WIDTH = 32;
    localparam int unsigned GROUP_BITS  = 7;
    localparam int unsigned MAX_GROUPS  = 4;
    localparam int unsigned DIGIT_WIDTH = GROUP_BITS * MAX_GROUPS;
    localparam int unsigned LEAD_BITS   = 6;

    typedef logic [2:0] group_count_t;

    typedef struct packed {
        logic                   neg;
        logic [VALUE_WIDTH-1:0] mag;
    } sve_item_t;

endpackage

FILE: rtl/sve_front.sv
module sve_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic signed [sve_pkg::VALUE_WIDTH-1:0] value,
    input  logic                                value_valid,
    output logic                                value_stall,
    input  logic                                item_take,
    output logic                                item_valid,
    output sve_pkg::sve_item_t                  item
);

    logic               hold_valid_reg;
    logic               hold_valid_next;
    sve_pkg::sve_item_t item_reg;
    sve_pkg::sve_item_t item_next;
    logic               accept;

    assign value_stall = hold_valid_reg && !item_take;
    assign accept      = value_valid && !value_stall;

    always_comb
    begin
        item_next.neg = value[sve_pkg::VALUE_WIDTH-1];
        item_next.mag = value[sve_pkg::VALUE_WIDTH-1]
                      ? (~value + 1'b1) : value;
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (item_take)
        begin
            hold_valid_next = 1'b0;
        end
        else
        begin
            hold_valid_next = hold_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = hold_valid_reg;
    assign item       = item_reg;

endmodule

FILE: rtl/sve_shifter.sv
module sve_shifter
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  sve_pkg::sve_item_t item,
    output logic               item_take,
    output logic [7:0]         code_byte,
    output logic               last,
    output logic               code_valid,
    input  logic               code_stall
);

    logic [sve_pkg::DIGIT_WIDTH-1:0] digits_reg;
    logic [sve_pkg::DIGIT_WIDTH-1:0] digits_next;
    logic [sve_pkg::DIGIT_WIDTH-1:0] load_digits;
    sve_pkg::group_count_t           rem_reg;
    sve_pkg::group_count_t           rem_next;
    sve_pkg::group_count_t           groups;
    logic [sve_pkg::LEAD_BITS-1:0]   lead;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [7:0]                      byte_reg;
    logic [7:0]                      byte_next;
    logic                            last_reg;
    logic                            last_next;
    logic                            slot_free;
    logic                            load;
    logic                            emit;
    logic [sve_pkg::VALUE_WIDTH-1:0] mag;

    assign mag       = item.mag;
    assign slot_free = !out_valid_reg || !code_stall;
    assign emit      = slot_free && (rem_reg != '0);
    assign load      = slot_free && (rem_reg == '0) && item_valid;
    assign item_take = load;

    always_comb
    begin
        if (|mag[31:27])
        begin
            groups = 3'd4;
        end
        else if (|mag[26:20])
        begin
            groups = 3'd3;
        end
        else if (|mag[19:13])
        begin
            groups = 3'd2;
        end
        else if (|mag[12:6])
        begin
            groups = 3'd1;
        end
        else
        begin
            groups = 3'd0;
        end
    end

    always_comb
    begin
        case (groups)
            3'd4:
            begin
                lead        = {2'b00, mag[31:28]};
                load_digits = mag[27:0];
            end
            3'd3:
            begin
                lead        = mag[26:21];
                load_digits = {mag[20:0], 7'b0};
            end
            3'd2:
            begin
                lead        = mag[19:14];
                load_digits = {mag[13:0], 14'b0};
            end
            3'd1:
            begin
                lead        = mag[12:7];
                load_digits = {mag[6:0], 21'b0};
            end
            default:
            begin
                lead        = mag[5:0];
                load_digits = '0;
            end
        endcase
    end

    always_comb
    begin
        digits_next    = digits_reg;
        rem_next       = rem_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && code_stall;
        if (emit)
        begin
            rem_next       = rem_reg - 3'd1;
            byte_next      = {(rem_reg != 3'd1),
                              digits_reg[sve_pkg::DIGIT_WIDTH-1 -: sve_pkg::GROUP_BITS]};
            last_next      = (rem_reg == 3'd1);
            digits_next    = {digits_reg[sve_pkg::DIGIT_WIDTH-sve_pkg::GROUP_BITS-1:0],
                              {sve_pkg::GROUP_BITS{1'b0}}};
            out_valid_next = 1'b1;
        end
        else if (load)
        begin
            rem_next       = groups;
            byte_next      = {(groups != '0), item.neg, lead};
            last_next      = (groups == '0);
            digits_next    = load_digits;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            rem_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            rem_reg       <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
        byte_reg   <= byte_next;
        last_reg   <= last_next;
    end

    assign code_byte  = byte_reg;
    assign last       = last_reg;
    assign code_valid = out_valid_reg;

    `include "signed_varint_encoder_assert.svh"

    `SVE_ASSERT_NOW(a_rem_range, 1'b1, rem_reg <= 3'd4, "remaining digit count out of range")
    `SVE_ASSERT_NOW(a_last_done, out_valid_reg && last_reg, rem_reg == '0, "digits after last")
    `SVE_ASSERT_NOW(a_more_left, out_valid_reg && !last_reg, rem_reg != '0, "no digits before last")
    `SVE_ASSERT_NEXT(a_load_shows, load, out_valid_reg, "loaded value produced no beat")

endmodule

FILE: rtl/signed_varint_encoder.sv
// An accepted value is registered in the input stage, and its first code byte is
// then registered in the shifter. One code byte per cycle while code_stall is low;
// a value gives 1 to 5 bytes (5 for magnitudes of 2^27 and above), 7-bit digits.
// A value is held in an input stage while the previous one is still shifting out.
// Reset (rst_n, asynchronous, active low) empties both stages; no pending bytes remain.
module signed_varint_encoder
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic signed [sve_pkg::VALUE_WIDTH-1:0] value,
    input  logic                                   value_valid,
    output logic                                   value_stall,
    output logic [7:0]                             code_byte,
    output logic                                   last,
    output logic                                   code_valid,
    input  logic                                   code_stall
);

    logic               item_valid;
    logic               item_take;
    sve_pkg::sve_item_t item;

    sve_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .value       (value),
        .value_valid (value_valid),
        .value_stall (value_stall),
        .item_take   (item_take),
        .item_valid  (item_valid),
        .item        (item)
    );

    sve_shifter u_shifter
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .code_byte  (code_byte),
        .last       (last),
        .code_valid (code_valid),
        .code_stall (code_stall)
    );

endmodule
